// File: rtl/core/tlg_pkg.sv
package tlg_pkg;

  // Input coordinate and intermediate widths.
  localparam int COORD_W = 32;
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W = PROD_W;
  localparam int EDIFF_W = PROD_W + 2;
  localparam int EMAG_W = PROD_W + 1;
  localparam int SQ_IN_W = EMAG_W;
  localparam int SQ_W = 2 * SQ_IN_W;
  localparam int SUM_W = 2 * MAG_W;
  localparam int QS_W = MAG_W + SUM_W;

  // Q32.32 output scaling: numerators are shifted left by three fraction widths.
  localparam int FRAC_SHIFT = 96;

  // Ratio square root unit: quotient bits and root bits.
  localparam int QUO_W = 126;
  localparam int ROOT_W = QUO_W / 2;

  // Output widths.
  localparam int COEF_W = 64;
  localparam int AREA_W = 63;

  // Area is sqrt(s / 4), so the area quotient is a right shift by two.
  localparam int AREA_SHIFT = 2;

  // Digit width of the pipelined multipliers.
  localparam int MUL_DIGIT_W = 34;

  typedef struct packed {
    logic [AREA_W-1:0] area;
    logic [COEF_W-1:0] gu0;
    logic [COEF_W-1:0] gu1;
    logic [COEF_W-1:0] gu2;
    logic [COEF_W-1:0] gv0;
    logic [COEF_W-1:0] gv1;
    logic [COEF_W-1:0] gv2;
    logic              degen;
  } res_t;

endpackage

// File: rtl/core/tlg_mul.sv
// Unsigned multiplier, one digit partial product per pipeline stage.
module tlg_mul import tlg_pkg::*; #(
  parameter int AW = SQ_IN_W,
  parameter int BW = SQ_IN_W,
  parameter int DigitW = MUL_DIGIT_W
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic [AW+BW-1:0] p_o
);

  localparam int NA = (AW + DigitW - 1) / DigitW;
  localparam int NB = (BW + DigitW - 1) / DigitW;
  localparam int NP = NA * NB;
  localparam int APW = NA * DigitW;
  localparam int BPW = NB * DigitW;
  localparam int PW = AW + BW;

  logic [APW-1:0] a_q   [NP];
  logic [BPW-1:0] b_q   [NP];
  logic [PW-1:0]  acc_q [NP];

  for (genvar p = 0; p < NP; p++) begin : g_pp
    localparam int IA = p / NB;
    localparam int IB = p % NB;
    logic [APW-1:0]      a_cur;
    logic [BPW-1:0]      b_cur;
    logic [PW-1:0]       acc_cur;
    logic [2*DigitW-1:0] part;

    // The first stage takes the operands straight from the ports.
    if (p == 0) begin : g_first
      assign a_cur = APW'(a_i);
      assign b_cur = BPW'(b_i);
      assign acc_cur = '0;
    end else begin : g_next
      assign a_cur = a_q[p-1];
      assign b_cur = b_q[p-1];
      assign acc_cur = acc_q[p-1];
    end

    assign part = a_cur[IA*DigitW +: DigitW] * b_cur[IB*DigitW +: DigitW];

    // Accumulate one weighted partial product.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[p] <= a_cur;
        b_q[p] <= b_cur;
        acc_q[p] <= acc_cur + (PW'(part) << ((IA + IB) * DigitW));
      end
    end
  end

  assign p_o = acc_q[NP-1];

endmodule

// File: rtl/core/tlg_ratio_sqrt.sv
// Pipelined floor(sqrt(num / den)), saturated to all ones in ROOT_W bits.
// One restoring division step per stage gives the quotient, then one root
// digit per stage.
module tlg_ratio_sqrt import tlg_pkg::*; #(
  parameter int NW = SUM_W,
  parameter int DW = SUM_W
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [NW-1:0]     num_i,
  input  logic [DW-1:0]     den_i,
  output logic [ROOT_W-1:0] root_o
);

  localparam int NPW = QUO_W + DW;
  localparam int RW = ROOT_W + 2;

  logic [NPW-1:0] num_pad;
  logic [DW-1:0]  num_top;

  logic [DW-1:0]     r_q    [QUO_W+1];
  logic [QUO_W-1:0]  nq_q   [QUO_W+1];
  logic [DW-1:0]     d_q    [QUO_W];
  logic              sat_q  [QUO_W+ROOT_W+1];
  logic [RW-1:0]     rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [QUO_W-1:0]  sq_q   [ROOT_W];

  // Setup: a quotient beyond QUO_W bits saturates the result.
  assign num_pad = NPW'(num_i);
  assign num_top = num_pad[NPW-1:QUO_W];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0] <= num_top;
      nq_q[0] <= num_pad[QUO_W-1:0];
      d_q[0] <= den_i;
      sat_q[0] <= (num_top >= den_i);
    end
  end

  // Division: shift in one numerator bit, shift out one quotient bit.
  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    logic [DW:0]   rs;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] rn;

    assign rs = {r_q[k], nq_q[k][QUO_W-1]};
    assign diff = rs - {1'b0, d_q[k]};
    assign ge = (rs >= {1'b0, d_q[k]});
    assign rn = ge ? diff[DW-1:0] : rs[DW-1:0];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k+1] <= rn;
        nq_q[k+1] <= {nq_q[k][QUO_W-2:0], ge};
        sat_q[k+1] <= sat_q[k];
      end
    end

    if (k < QUO_W - 1) begin : g_den
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          d_q[k+1] <= d_q[k];
        end
      end
    end
  end

  // Square root: one root bit per stage from two quotient bits.
  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    logic [RW-1:0]     rem_cur;
    logic [ROOT_W-1:0] root_cur;
    logic [QUO_W-1:0]  sq_cur;
    logic [RW+1:0]     rem4;
    logic [RW+1:0]     trial;
    logic [RW+1:0]     diff;
    logic              ge;

    if (j == 0) begin : g_first
      assign rem_cur = '0;
      assign root_cur = '0;
      assign sq_cur = nq_q[QUO_W];
    end else begin : g_next
      assign rem_cur = rem_q[j-1];
      assign root_cur = root_q[j-1];
      assign sq_cur = sq_q[j-1];
    end

    assign rem4 = {rem_cur, sq_cur[QUO_W-1:QUO_W-2]};
    assign trial = (RW+2)'({root_cur, 2'b01});
    assign diff = rem4 - trial;
    assign ge = (rem4 >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? diff[RW-1:0] : rem4[RW-1:0];
        root_q[j] <= {root_cur[ROOT_W-2:0], ge};
        sq_q[j] <= {sq_cur[QUO_W-3:0], 2'b00};
        sat_q[QUO_W+1+j] <= sat_q[QUO_W+j];
      end
    end
  end

  assign root_o = sat_q[QUO_W+ROOT_W] ? '1 : root_q[ROOT_W-1];

endmodule

// File: rtl/core/triangle_local_gradient_frame_unit.sv
// Triangle local gradient frame unit.
// Input channel (in_valid_i / in_ready_o) carries one triangle per transaction
// as nine signed Q16.16 coordinates. Output channel (out_valid_o / out_ready_i)
// returns one transaction per triangle: the area (unsigned Q31.32), the six
// gradient coefficients (signed Q32.32) and the degenerate flag. Results leave
// in input order.
// Depth: the ratio square root units set most of the pipeline depth, with 126
// division steps and 63 root steps, one per stage. Throughput: one triangle per
// cycle while the output is not stalled; every stage holds one transaction.
// When the receiver stalls, one more transaction moves into a skid register,
// then the whole pipeline holds and in_ready_o drops until the output drains.
// Reset clears all valid bits and the output and skid valid flags; datapath
// registers are not reset. The block has no configuration and no state that
// carries from one triangle to the next.
module triangle_local_gradient_frame_unit import tlg_pkg::*; #(
  parameter int DigitW = MUL_DIGIT_W
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [COORD_W-1:0] ax_i,
  input  logic signed [COORD_W-1:0] ay_i,
  input  logic signed [COORD_W-1:0] az_i,
  input  logic signed [COORD_W-1:0] bx_i,
  input  logic signed [COORD_W-1:0] by_coord_i,
  input  logic signed [COORD_W-1:0] bz_i,
  input  logic signed [COORD_W-1:0] px_i,
  input  logic signed [COORD_W-1:0] py_i,
  input  logic signed [COORD_W-1:0] pz_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [AREA_W-1:0]         area_o,
  output logic signed [COEF_W-1:0]  gu0_o,
  output logic signed [COEF_W-1:0]  gu1_o,
  output logic signed [COEF_W-1:0]  gu2_o,
  output logic signed [COEF_W-1:0]  gv0_o,
  output logic signed [COEF_W-1:0]  gv1_o,
  output logic signed [COEF_W-1:0]  gv2_o,
  output logic                      degenerate_o
);

  localparam int SQ_DIG = (SQ_IN_W + DigitW - 1) / DigitW;
  localparam int LSQ = SQ_DIG * SQ_DIG;
  localparam int LQS = ((MAG_W + DigitW - 1) / DigitW) * ((SUM_W + DigitW - 1) / DigitW);
  localparam int LAT = 1 + QUO_W + ROOT_W;
  localparam int TOT = 7 + LSQ + LQS + LAT;
  localparam int DL1_W = MAG_W + 2;
  localparam int DL2_W = SQ_W + SQ_W + MAG_W + SUM_W + 2;
  localparam int GU_NUM_W = FRAC_SHIFT + 1;
  localparam int ADL = LAT - ROOT_W;

  logic en;
  logic [TOT-1:0] vld_q;
  logic out_vld_q;
  logic skid_vld_q;

  logic [COORD_W-1:0] va [3];
  logic [COORD_W-1:0] vb [3];
  logic [COORD_W-1:0] vp [3];

  assign va[0] = ax_i;
  assign va[1] = ay_i;
  assign va[2] = az_i;
  assign vb[0] = bx_i;
  assign vb[1] = by_coord_i;
  assign vb[2] = bz_i;
  assign vp[0] = px_i;
  assign vp[1] = py_i;
  assign vp[2] = pz_i;

  // The pipeline advances whenever the skid register is empty.
  assign en = !skid_vld_q;
  assign in_ready_o = en;

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TOT-2:0], in_valid_i};
    end
  end

  // Stage 1: edge vectors from vertex A.
  logic signed [DIFF_W-1:0] e1_q [3];
  logic signed [DIFF_W-1:0] e2_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_q[i] <= $signed({vb[i][COORD_W-1], vb[i]}) - $signed({va[i][COORD_W-1], va[i]});
        e2_q[i] <= $signed({vp[i][COORD_W-1], vp[i]}) - $signed({va[i][COORD_W-1], va[i]});
      end
    end
  end

  // Stage 2: products for the cross product, edge length and dot product.
  logic signed [PROD_W-1:0] cpa_q [3];
  logic signed [PROD_W-1:0] cpb_q [3];
  logic signed [PROD_W-1:0] qq_q  [3];
  logic signed [PROD_W-1:0] dd_q  [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      cpa_q[0] <= e1_q[1] * e2_q[2];
      cpb_q[0] <= e1_q[2] * e2_q[1];
      cpa_q[1] <= e1_q[2] * e2_q[0];
      cpb_q[1] <= e1_q[0] * e2_q[2];
      cpa_q[2] <= e1_q[0] * e2_q[1];
      cpb_q[2] <= e1_q[1] * e2_q[0];
      for (int i = 0; i < 3; i++) begin
        qq_q[i] <= e1_q[i] * e1_q[i];
        dd_q[i] <= e1_q[i] * e2_q[i];
      end
    end
  end

  // Stage 3: cross product components, squared edge length, dot product.
  logic signed [CROSS_W-1:0] c3_q [3];
  logic [MAG_W-1:0]          q3_q;
  logic signed [CROSS_W-1:0] d3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c3_q[i] <= cpa_q[i] - cpb_q[i];
      end
      q3_q <= $unsigned(qq_q[0]) + $unsigned(qq_q[1]) + $unsigned(qq_q[2]);
      d3_q <= dd_q[0] + dd_q[1] + dd_q[2];
    end
  end

  // Stage 4: magnitudes and the difference of dot product and length.
  logic [MAG_W-1:0]          cabs4_q [3];
  logic [MAG_W-1:0]          dabs4_q;
  logic [MAG_W-1:0]          q4_q;
  logic signed [EDIFF_W-1:0] e4_q;
  logic                      dpos4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cabs4_q[i] <= c3_q[i][CROSS_W-1] ? MAG_W'(-c3_q[i]) : MAG_W'(c3_q[i]);
      end
      dabs4_q <= d3_q[CROSS_W-1] ? MAG_W'(-d3_q) : MAG_W'(d3_q);
      dpos4_q <= !d3_q[CROSS_W-1] && (d3_q != '0);
      e4_q <= $signed({d3_q[CROSS_W-1], d3_q}) - $signed({2'b00, q3_q});
      q4_q <= q3_q;
    end
  end

  // Stage 5: magnitude of the difference.
  logic [MAG_W-1:0]  cabs5_q [3];
  logic [MAG_W-1:0]  dabs5_q;
  logic [MAG_W-1:0]  q5_q;
  logic [EMAG_W-1:0] eabs5_q;
  logic              eneg5_q;
  logic              dpos5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cabs5_q <= cabs4_q;
      dabs5_q <= dabs4_q;
      q5_q <= q4_q;
      dpos5_q <= dpos4_q;
      eneg5_q <= e4_q[EDIFF_W-1];
      eabs5_q <= e4_q[EDIFF_W-1] ? EMAG_W'(-e4_q) : EMAG_W'(e4_q);
    end
  end

  // Squares of the cross components, the difference and the dot product.
  logic [SQ_W-1:0] sqc [3];
  logic [SQ_W-1:0] sqe;
  logic [SQ_W-1:0] sqd;

  for (genvar i = 0; i < 3; i++) begin : g_sqc
    tlg_mul #(
      .AW     (SQ_IN_W),
      .BW     (SQ_IN_W),
      .DigitW (DigitW)
    ) u_mul_c (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   ({1'b0, cabs5_q[i]}),
      .b_i   ({1'b0, cabs5_q[i]}),
      .p_o   (sqc[i])
    );
  end

  tlg_mul #(
    .AW     (SQ_IN_W),
    .BW     (SQ_IN_W),
    .DigitW (DigitW)
  ) u_mul_e (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (eabs5_q),
    .b_i   (eabs5_q),
    .p_o   (sqe)
  );

  tlg_mul #(
    .AW     (SQ_IN_W),
    .BW     (SQ_IN_W),
    .DigitW (DigitW)
  ) u_mul_d (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   ({1'b0, dabs5_q}),
    .b_i   ({1'b0, dabs5_q}),
    .p_o   (sqd)
  );

  // Length and signs wait for the squares.
  logic [DL1_W-1:0] dl1_q [LSQ];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dl1_q[0] <= {q5_q, eneg5_q, dpos5_q};
      for (int k = 1; k < LSQ; k++) begin
        dl1_q[k] <= dl1_q[k-1];
      end
    end
  end

  // Sum of squares: the squared cross product norm.
  logic [SUM_W-1:0] s10_q;
  logic [SQ_W-1:0]  e2_10_q;
  logic [SQ_W-1:0]  d2_10_q;
  logic [MAG_W-1:0] q10_q;
  logic             eneg10_q;
  logic             dpos10_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s10_q <= SUM_W'(sqc[0] + sqc[1] + sqc[2]);
      e2_10_q <= sqe;
      d2_10_q <= sqd;
      {q10_q, eneg10_q, dpos10_q} <= dl1_q[LSQ-1];
    end
  end

  // Shared denominator of the second row.
  logic [QS_W-1:0] qs;

  tlg_mul #(
    .AW     (MAG_W),
    .BW     (SUM_W),
    .DigitW (DigitW)
  ) u_mul_qs (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (q10_q),
    .b_i   (s10_q),
    .p_o   (qs)
  );

  logic [DL2_W-1:0] dl2_q [LQS];
  logic [SQ_W-1:0]  e2_r;
  logic [SQ_W-1:0]  d2_r;
  logic [MAG_W-1:0] q_r;
  logic [SUM_W-1:0] s_r;
  logic             eneg_r;
  logic             dpos_r;
  logic             degen_r;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dl2_q[0] <= {e2_10_q, d2_10_q, q10_q, s10_q, eneg10_q, dpos10_q};
      for (int k = 1; k < LQS; k++) begin
        dl2_q[k] <= dl2_q[k-1];
      end
    end
  end

  assign {e2_r, d2_r, q_r, s_r, eneg_r, dpos_r} = dl2_q[LQS-1];
  assign degen_r = (s_r == '0);

  // Ratio square roots for the area and the four distinct magnitudes.
  logic [ROOT_W-1:0] g_area;
  logic [ROOT_W-1:0] g_gu;
  logic [ROOT_W-1:0] g_gv0;
  logic [ROOT_W-1:0] g_gv1;
  logic [ROOT_W-1:0] g_gv2;

  // Area: the quotient by four is a shift, and a quotient beyond QUO_W bits
  // saturates. One root bit per stage, then a delay line matches the ratio units.
  logic [QUO_W-1:0]  area_quo;
  logic              area_sat;
  logic [ROOT_W+1:0] arem_q  [ROOT_W];
  logic [ROOT_W-1:0] aroot_q [ROOT_W];
  logic [QUO_W-1:0]  asq_q   [ROOT_W];
  logic              asat_q  [ROOT_W];
  logic [ROOT_W:0]   adl_q   [ADL];

  assign area_quo = s_r[QUO_W+AREA_SHIFT-1:AREA_SHIFT];
  assign area_sat = (s_r[SUM_W-1:QUO_W+AREA_SHIFT] != '0);

  for (genvar j = 0; j < ROOT_W; j++) begin : g_area_sqrt
    logic [ROOT_W+1:0] rem_cur;
    logic [ROOT_W-1:0] root_cur;
    logic [QUO_W-1:0]  sq_cur;
    logic              sat_cur;
    logic [ROOT_W+3:0] rem4;
    logic [ROOT_W+3:0] trial;
    logic [ROOT_W+3:0] diff;
    logic              ge;

    if (j == 0) begin : g_first
      assign rem_cur = '0;
      assign root_cur = '0;
      assign sq_cur = area_quo;
      assign sat_cur = area_sat;
    end else begin : g_next
      assign rem_cur = arem_q[j-1];
      assign root_cur = aroot_q[j-1];
      assign sq_cur = asq_q[j-1];
      assign sat_cur = asat_q[j-1];
    end

    assign rem4 = {rem_cur, sq_cur[QUO_W-1:QUO_W-2]};
    assign trial = (ROOT_W+4)'({root_cur, 2'b01});
    assign diff = rem4 - trial;
    assign ge = (rem4 >= trial);

    always_ff @(posedge clk_i) begin
      if (en) begin
        arem_q[j] <= ge ? diff[ROOT_W+1:0] : rem4[ROOT_W+1:0];
        aroot_q[j] <= {root_cur[ROOT_W-2:0], ge};
        asq_q[j] <= {sq_cur[QUO_W-3:0], 2'b00};
        asat_q[j] <= sat_cur;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      adl_q[0] <= {asat_q[ROOT_W-1], aroot_q[ROOT_W-1]};
      for (int k = 1; k < ADL; k++) begin
        adl_q[k] <= adl_q[k-1];
      end
    end
  end

  assign g_area = adl_q[ADL-1][ROOT_W] ? '1 : adl_q[ADL-1][ROOT_W-1:0];

  tlg_ratio_sqrt #(
    .NW (GU_NUM_W),
    .DW (MAG_W)
  ) u_rs_gu (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  ({1'b1, {FRAC_SHIFT{1'b0}}}),
    .den_i  (q_r),
    .root_o (g_gu)
  );

  tlg_ratio_sqrt #(
    .NW (SQ_W + FRAC_SHIFT),
    .DW (QS_W)
  ) u_rs_gv0 (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  ({e2_r, {FRAC_SHIFT{1'b0}}}),
    .den_i  (qs),
    .root_o (g_gv0)
  );

  tlg_ratio_sqrt #(
    .NW (SQ_W + FRAC_SHIFT),
    .DW (QS_W)
  ) u_rs_gv1 (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  ({d2_r, {FRAC_SHIFT{1'b0}}}),
    .den_i  (qs),
    .root_o (g_gv1)
  );

  tlg_ratio_sqrt #(
    .NW (MAG_W + FRAC_SHIFT),
    .DW (SUM_W)
  ) u_rs_gv2 (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  ({q_r, {FRAC_SHIFT{1'b0}}}),
    .den_i  (s_r),
    .root_o (g_gv2)
  );

  // Flags wait for the ratio units.
  logic [2:0] dl3_q [LAT];
  logic       degen_f;
  logic       eneg_f;
  logic       dpos_f;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dl3_q[0] <= {degen_r, eneg_r, dpos_r};
      for (int k = 1; k < LAT; k++) begin
        dl3_q[k] <= dl3_q[k-1];
      end
    end
  end

  assign {degen_f, eneg_f, dpos_f} = dl3_q[LAT-1];

  // Final stage: apply signs and the degenerate case.
  logic [COEF_W-1:0] mag_gu;
  logic [COEF_W-1:0] mag_gv0;
  logic [COEF_W-1:0] mag_gv1;
  logic [COEF_W-1:0] mag_gv2;
  res_t              fin_d;
  res_t              fin_q;

  assign mag_gu = COEF_W'(g_gu);
  assign mag_gv0 = COEF_W'(g_gv0);
  assign mag_gv1 = COEF_W'(g_gv1);
  assign mag_gv2 = COEF_W'(g_gv2);

  always_comb begin
    fin_d = '0;
    fin_d.degen = degen_f;
    if (!degen_f) begin
      fin_d.area = g_area;
      fin_d.gu0 = '0 - mag_gu;
      fin_d.gu1 = mag_gu;
      fin_d.gv0 = eneg_f ? ('0 - mag_gv0) : mag_gv0;
      fin_d.gv1 = dpos_f ? ('0 - mag_gv1) : mag_gv1;
      fin_d.gv2 = mag_gv2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_q <= fin_d;
    end
  end

  // Output register with a skid register behind it.
  res_t out_q;
  res_t skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || out_ready_i) begin
      if (skid_vld_q) begin
        out_vld_q <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= vld_q[TOT-1];
      end
    end else if (en && vld_q[TOT-1]) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || out_ready_i) begin
      out_q <= skid_vld_q ? skid_q : fin_q;
    end else if (en && vld_q[TOT-1]) begin
      skid_q <= fin_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign area_o = out_q.area;
  assign gu0_o = out_q.gu0;
  assign gu1_o = out_q.gu1;
  assign gu2_o = out_q.gu2;
  assign gv0_o = out_q.gv0;
  assign gv1_o = out_q.gv1;
  assign gv2_o = out_q.gv2;
  assign degenerate_o = out_q.degen;

endmodule
